// ===== design/psimp_pkg.sv =====
// ----------------------------------------------------------------------------
// Path simplifier package
// Shared sizes, character codes and the result word type of the path
// simplifier.
// ----------------------------------------------------------------------------
package psimp_pkg;

  // Storage sizes.
  localparam int BUF_DEPTH   = 64;
  localparam int STACK_DEPTH = 32;
  localparam int BUF_AW      = $clog2(BUF_DEPTH);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  // Fixed state widths.
  localparam int LEN_W = 7;   // committed length and segment length
  localparam int CNT_W = 6;   // component count
  localparam int SUM_W = 8;   // committed length plus segment length

  localparam logic [LEN_W-1:0] SEG_MAX = 7'd127;

  // Character codes.
  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT   = 8'h2E;

  // One result word handed to the output register.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflow;
  } emit_t;

endpackage

// ===== design/psimp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered and held
// while no read is enabled.
// ----------------------------------------------------------------------------
module psimp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/psimp_outreg.sv =====
// ----------------------------------------------------------------------------
// Path simplifier output register
// Holds one result word toward the master side and reports when it can
// take the next one.
// ----------------------------------------------------------------------------
module psimp_outreg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  psimp_pkg::emit_t      din,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] out_char
  output logic                  m_tlast,   // out_last
  output logic                  m_tuser    // [0] overflow
);

  psimp_pkg::emit_t word;

  // The slot is free when empty or when its word leaves this cycle.
  assign free = !m_tvalid || m_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      word <= din;
    end
  end

  assign m_tdata = word.out_char;
  assign m_tlast = word.out_last;
  assign m_tuser = word.overflow;

endmodule

// ===== design/unix_path_simplifier.sv =====
// ----------------------------------------------------------------------------
// Unix path simplifier
// Builds the canonical form of a path fed one byte per word and sends it
// out byte by byte after the final input byte.
// ----------------------------------------------------------------------------
// Throughput: one path byte per cycle, but a ".." that pops a component stalls
//   intake for a stack read in S_POP, and intake stops from the final byte until
//   the last output word is loaded. The burst runs at one word per cycle while
//   m_tready is high. Before the first output word the control passes S_CLOSE
//   after a final name byte, S_POPF when that close pops, then S_TAIL and S_CHECK
//   for two buffer reads. Reset: synchronous; clears control state only.
// ----------------------------------------------------------------------------
module unix_path_simplifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,   // out_last
  output logic       m_tuser    // [0] overflow
);

  typedef enum logic [2:0] {
    S_RUN, S_CLOSE, S_POP, S_POPF, S_TAIL, S_CHECK, S_EMIT
  } state_t;

  state_t state, state_next;

  logic [psimp_pkg::LEN_W-1:0]  cl, cl_next;
  logic [psimp_pkg::LEN_W-1:0]  sl, sl_next;
  logic                         dots, dots_next;
  logic [psimp_pkg::CNT_W-1:0]  count, count_next;
  logic                         ovf, ovf_next;
  logic [psimp_pkg::BUF_AW-1:0] idx, idx_next;
  logic [psimp_pkg::BUF_AW-1:0] last_idx, last_idx_next;

  // Memory ports.
  logic                           buf_we, buf_re;
  logic [psimp_pkg::BUF_AW-1:0]   buf_waddr, buf_raddr;
  logic [7:0]                     buf_wdata, buf_rdata;
  logic                           stk_we, stk_re;
  logic [psimp_pkg::STACK_AW-1:0] stk_waddr, stk_raddr;
  logic [psimp_pkg::LEN_W-1:0]    stk_rdata;

  // Output register.
  logic             out_load, out_free;
  psimp_pkg::emit_t out_word;

  // Shared arithmetic.
  logic                         acc;
  logic [psimp_pkg::SUM_W-1:0]  pos;
  logic                         pos_full;
  logic [psimp_pkg::CNT_W-1:0]  cnt_dec;
  logic [psimp_pkg::LEN_W-1:0]  cl_dec;
  logic                         do_close, do_take, popping;
  logic                         seg_drop, seg_pop;
  logic [psimp_pkg::LEN_W-1:0]  n_len;

  assign s_tready = (state == S_RUN);
  assign acc      = s_tvalid && s_tready;

  // Write position of the next name byte, equal to the end of a closing segment.
  assign pos      = {1'b0, cl} + {1'b0, sl};
  assign pos_full = (pos >= psimp_pkg::SUM_W'(psimp_pkg::BUF_DEPTH));
  assign cnt_dec  = count - 1'b1;
  assign cl_dec   = cl - 1'b1;

  // Classify the open segment.
  assign seg_drop = (sl == '0) || (dots && (sl == psimp_pkg::LEN_W'(1)));
  assign seg_pop  = dots && (sl == psimp_pkg::LEN_W'(2));

  assign do_close = (state == S_CLOSE) || (acc && (s_tdata == psimp_pkg::SLASH));
  assign do_take  = acc && (s_tdata != psimp_pkg::SLASH);
  assign popping  = do_close && seg_pop && (count != '0);

  // Trim a trailing slash from the emitted length.
  assign n_len = ((cl > psimp_pkg::LEN_W'(1)) && (buf_rdata == psimp_pkg::SLASH)) ?
                 cl_dec : cl;

  // Path update and sequencing.
  always_comb begin
    state_next    = state;
    cl_next       = cl;
    sl_next       = sl;
    dots_next     = dots;
    count_next    = count;
    ovf_next      = ovf;
    idx_next      = idx;
    last_idx_next = last_idx;
    buf_we        = 1'b0;
    buf_waddr     = pos[psimp_pkg::BUF_AW-1:0];
    buf_wdata     = s_tdata;
    buf_re        = 1'b0;
    buf_raddr     = idx;
    stk_we        = 1'b0;
    stk_waddr     = count[psimp_pkg::STACK_AW-1:0];
    stk_re        = 1'b0;
    stk_raddr     = cnt_dec[psimp_pkg::STACK_AW-1:0];
    out_load      = 1'b0;
    out_word      = '{out_char: buf_rdata, out_last: 1'b0, overflow: ovf};

    // A name byte goes into the open segment.
    if (do_take) begin
      if (!pos_full) begin
        buf_we = 1'b1;
      end else begin
        ovf_next = 1'b1;
      end
      if (sl != psimp_pkg::SEG_MAX) begin
        sl_next = sl + 1'b1;
      end
      if (s_tdata != psimp_pkg::DOT) begin
        dots_next = 1'b0;
      end
    end

    // Close the open segment: drop it, pop a component or keep it.
    if (do_close) begin
      sl_next   = '0;
      dots_next = 1'b1;
      if (popping) begin
        count_next = cnt_dec;
        stk_re     = 1'b1;
      end else if (!seg_drop && !seg_pop) begin
        if (count == psimp_pkg::CNT_W'(psimp_pkg::STACK_DEPTH)) begin
          ovf_next = 1'b1;
        end else begin
          stk_we     = 1'b1;
          count_next = count + 1'b1;
          if (pos_full) begin
            cl_next = psimp_pkg::LEN_W'(psimp_pkg::BUF_DEPTH);
          end else begin
            buf_we    = 1'b1;
            buf_wdata = psimp_pkg::SLASH;
            cl_next   = pos[psimp_pkg::LEN_W-1:0] + 1'b1;
          end
        end
      end
    end

    case (state)
      S_RUN: begin
        if (acc) begin
          if (s_tdata == psimp_pkg::SLASH) begin
            if (popping) begin
              state_next = s_tlast ? S_POPF : S_POP;
            end else begin
              state_next = s_tlast ? S_TAIL : S_RUN;
            end
          end else begin
            state_next = s_tlast ? S_CLOSE : S_RUN;
          end
        end
      end
      S_CLOSE: begin
        state_next = popping ? S_POPF : S_TAIL;
      end
      S_POP: begin
        cl_next    = stk_rdata;
        state_next = S_RUN;
      end
      S_POPF: begin
        cl_next    = stk_rdata;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        // Fetch the last stored byte to see whether it is a slash.
        buf_re     = 1'b1;
        buf_raddr  = cl_dec[psimp_pkg::BUF_AW-1:0];
        state_next = S_CHECK;
      end
      S_CHECK: begin
        last_idx_next = cl_dec[psimp_pkg::BUF_AW-1:0];
        if (n_len != cl) begin
          last_idx_next = n_len[psimp_pkg::BUF_AW-1:0] - 1'b1;
        end
        buf_re     = 1'b1;
        buf_raddr  = '0;
        idx_next   = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_word.out_last = (idx == last_idx);
          if (idx == '0) begin
            out_word.out_char = psimp_pkg::SLASH;
          end
          if (idx == last_idx) begin
            cl_next    = psimp_pkg::LEN_W'(1);
            sl_next    = '0;
            dots_next  = 1'b1;
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_RUN;
          end else begin
            idx_next  = idx + 1'b1;
            buf_re    = 1'b1;
            buf_raddr = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      cl    <= psimp_pkg::LEN_W'(1);
      sl    <= '0;
      dots  <= 1'b1;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      cl    <= cl_next;
      sl    <= sl_next;
      dots  <= dots_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // Burst position registers.
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    last_idx <= last_idx_next;
  end

  // Path buffer.
  psimp_ram #(
    .WIDTH (8),
    .DEPTH (psimp_pkg::BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Component start stack.
  psimp_ram #(
    .WIDTH (psimp_pkg::LEN_W),
    .DEPTH (psimp_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (cl),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Output register.
  psimp_outreg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .din      (out_word),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // The committed length stays within the buffer and never drops below the root.
  a_cl_range: assert property (@(posedge clk) disable iff (rst)
    (cl >= psimp_pkg::LEN_W'(1)) && (cl <= psimp_pkg::LEN_W'(psimp_pkg::BUF_DEPTH)))
    else $error("committed length out of range");

  // The component count never exceeds the stack depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= psimp_pkg::CNT_W'(psimp_pkg::STACK_DEPTH))
    else $error("component count beyond stack depth");

  // The final input byte always stops intake for the output burst.
  a_final_stall: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input taken right after the final byte");

  // A word is loaded only into a free output slot.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output word overwritten");

endmodule
